// ----- design/lruf_pkg.sv -----
// ----------------------------------------------------------------------------
// lruf_pkg
// Sizes, index types and helpers shared by the LRU duplicate filter.
// ----------------------------------------------------------------------------
package lruf_pkg;

  localparam int CAPACITY = 64;
  localparam int BUCKETS  = 128;
  localparam int KEY_BITS = 64;

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SLOT_W = $clog2(CAPACITY + 1);
  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int HELD_W = 7;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [BKT_W-1:0]    bkt_t;
  typedef logic [KEY_BITS-1:0] key_t;

  // slot value that marks "no entry"
  localparam slot_t EMPTY = SLOT_W'(CAPACITY);

  function automatic logic is_empty(input slot_t s);
    is_empty = (s >= EMPTY);
  endfunction

  // low key bits pick the bucket
  function automatic bkt_t bucket_of(input key_t k);
    bucket_of = k[BKT_W-1:0];
  endfunction

endpackage

// ----- design/lruf_ram.sv -----
// ----------------------------------------------------------------------------
// lruf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lruf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/lru_duplicate_filter_unit.sv -----
// ----------------------------------------------------------------------------
// lru_duplicate_filter_unit
// LRU set of keys with bucket chains and a doubly linked recency list.
// ----------------------------------------------------------------------------
// Each request carries one key; the result says whether the key was already
// held and how many entries are held afterwards. One request is processed at
// a time by a sequencer around single-port-read RAMs (key store, chain links,
// bucket heads, recency prev/next). Each request walks the chain of its key's
// bucket; a miss in a full set also walks the evicted entry's chain to unlink
// it. A finished result sits in an output register, so the next request is
// taken while it waits.
module lru_duplicate_filter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        duplicate,
  output logic [6:0]  entries_held
);
  import lruf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_HEAD, S_CMP, S_EVKEY, S_EVHEAD, S_EVWALK, S_INSRD, S_INSHEAD,
    S_UNLINK, S_NEW1, S_NEW2, S_OUT
  } state_t;

  state_t state, state_next;
  key_t   key_q, key_q_next;
  slot_t  cur, cur_next, prior, prior_next, slot, slot_next;
  slot_t  steps, steps_next, count, count_next;
  slot_t  newest, newest_next, oldest, oldest_next;
  bkt_t   ev_bkt, ev_bkt_next;
  logic   dup, dup_next, evict, evict_next;
  logic   out_valid_next, duplicate_next;
  logic [6:0] entries_held_next;

  // RAM ports
  logic  key_we, link_we, head_we, prev_we, next_we;
  idx_t  key_wa, link_wa, prev_wa, next_wa, key_ra, link_ra, prev_ra, next_ra;
  bkt_t  head_wa, head_ra;
  key_t  key_wd, key_rd;
  slot_t link_wd, link_rd, head_wd, head_rd, prev_wd, prev_rd, next_wd, next_rd;

  logic [BUCKETS-1:0] head_vld;
  logic  head_rd_vld;
  slot_t head_val, nxt, steps_inc, evs;
  logic  go_miss;

  lruf_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key (
    .clk, .we(key_we), .waddr(key_wa), .wdata(key_wd), .raddr(key_ra), .rdata(key_rd));
  lruf_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link (
    .clk, .we(link_we), .waddr(link_wa), .wdata(link_wd), .raddr(link_ra), .rdata(link_rd));
  lruf_ram #(.WIDTH(SLOT_W), .DEPTH(BUCKETS)) u_head (
    .clk, .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(head_ra), .rdata(head_rd));
  lruf_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_prev (
    .clk, .we(prev_we), .waddr(prev_wa), .wdata(prev_wd), .raddr(prev_ra), .rdata(prev_rd));
  lruf_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_next (
    .clk, .we(next_we), .waddr(next_wa), .wdata(next_wd), .raddr(next_ra), .rdata(next_rd));

  assign in_ready  = (state == S_IDLE);
  assign head_val  = head_rd_vld ? head_rd : EMPTY;
  assign nxt       = link_rd;
  assign steps_inc = steps + SLOT_W'(1);
  assign evs       = is_empty(oldest) ? '0 : oldest;

  always_comb begin
    state_next        = state;
    key_q_next        = key_q;
    cur_next          = cur;
    prior_next        = prior;
    slot_next         = slot;
    steps_next        = steps;
    count_next        = count;
    newest_next       = newest;
    oldest_next       = oldest;
    ev_bkt_next       = ev_bkt;
    dup_next          = dup;
    evict_next        = evict;
    out_valid_next    = out_valid && !out_ready;
    duplicate_next    = duplicate;
    entries_held_next = entries_held;
    go_miss           = 1'b0;
    key_we = 1'b0; key_wa = slot[IDX_W-1:0]; key_wd = key_q; key_ra = '0;
    link_we = 1'b0; link_wa = '0; link_wd = '0; link_ra = '0;
    head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
    prev_we = 1'b0; prev_wa = '0; prev_wd = '0; prev_ra = '0;
    next_we = 1'b0; next_wa = '0; next_wd = '0; next_ra = '0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          key_q_next = key[KEY_BITS-1:0];
          head_ra    = bucket_of(key[KEY_BITS-1:0]);
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        steps_next = '0;
        if (is_empty(head_val)) begin
          go_miss = 1'b1;
        end else begin
          cur_next   = head_val;
          key_ra     = head_val[IDX_W-1:0];
          link_ra    = head_val[IDX_W-1:0];
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (key_rd == key_q) begin
          dup_next   = 1'b1;
          evict_next = 1'b0;
          slot_next  = cur;
          prev_ra    = cur[IDX_W-1:0];
          next_ra    = cur[IDX_W-1:0];
          state_next = S_UNLINK;
        end else if (is_empty(nxt) || steps_inc == EMPTY) begin
          go_miss = 1'b1;
        end else begin
          cur_next   = nxt;
          steps_next = steps_inc;
          key_ra     = nxt[IDX_W-1:0];
          link_ra    = nxt[IDX_W-1:0];
        end
      end
      S_EVKEY: begin
        ev_bkt_next = bucket_of(key_rd);
        head_ra     = bucket_of(key_rd);
        state_next  = S_EVHEAD;
      end
      S_EVHEAD: begin
        prior_next = EMPTY;
        steps_next = '0;
        if (is_empty(head_val)) begin
          state_next = S_INSRD;
        end else begin
          cur_next   = head_val;
          link_ra    = head_val[IDX_W-1:0];
          state_next = S_EVWALK;
        end
      end
      S_EVWALK: begin
        if (cur == slot) begin
          // drop the evicted entry from its chain
          if (!is_empty(prior)) begin
            link_we = 1'b1;
            link_wa = prior[IDX_W-1:0];
            link_wd = nxt;
          end else begin
            head_we = 1'b1;
            head_wa = ev_bkt;
            head_wd = nxt;
          end
          state_next = S_INSRD;
        end else if (is_empty(nxt) || steps_inc == EMPTY) begin
          state_next = S_INSRD;
        end else begin
          prior_next = cur;
          cur_next   = nxt;
          steps_next = steps_inc;
          link_ra    = nxt[IDX_W-1:0];
        end
      end
      S_INSRD: begin
        head_ra    = bucket_of(key_q);
        state_next = S_INSHEAD;
      end
      S_INSHEAD: begin
        key_we  = 1'b1;
        link_we = 1'b1;
        link_wa = slot[IDX_W-1:0];
        link_wd = head_val;
        head_we = 1'b1;
        head_wa = bucket_of(key_q);
        head_wd = slot;
        if (evict) begin
          prev_ra    = slot[IDX_W-1:0];
          next_ra    = slot[IDX_W-1:0];
          state_next = S_UNLINK;
        end else begin
          state_next = S_NEW1;
        end
      end
      S_UNLINK: begin
        if (!is_empty(prev_rd)) begin
          next_we = 1'b1;
          next_wa = prev_rd[IDX_W-1:0];
          next_wd = next_rd;
        end else begin
          newest_next = next_rd;
        end
        if (!is_empty(next_rd)) begin
          prev_we = 1'b1;
          prev_wa = next_rd[IDX_W-1:0];
          prev_wd = prev_rd;
        end else begin
          oldest_next = prev_rd;
        end
        state_next = S_NEW1;
      end
      S_NEW1: begin
        prev_we    = 1'b1;
        prev_wa    = slot[IDX_W-1:0];
        prev_wd    = EMPTY;
        next_we    = 1'b1;
        next_wa    = slot[IDX_W-1:0];
        next_wd    = newest;
        state_next = S_NEW2;
      end
      S_NEW2: begin
        if (!is_empty(newest)) begin
          prev_we = 1'b1;
          prev_wa = newest[IDX_W-1:0];
          prev_wd = slot;
        end
        newest_next = slot;
        if (is_empty(oldest)) begin
          oldest_next = slot;
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_valid_next    = 1'b1;
          duplicate_next    = dup;
          entries_held_next = 7'(count);
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (go_miss) begin
      dup_next = 1'b0;
      if (count < EMPTY) begin
        evict_next = 1'b0;
        slot_next  = count;
        count_next = count + SLOT_W'(1);
        head_ra    = bucket_of(key_q);
        state_next = S_INSHEAD;
      end else begin
        // full: reuse the oldest slot, fetch its key to find its chain
        evict_next = 1'b1;
        slot_next  = evs;
        key_ra     = evs[IDX_W-1:0];
        state_next = S_EVKEY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      newest    <= EMPTY;
      oldest    <= EMPTY;
      out_valid <= 1'b0;
      head_vld  <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      newest    <= newest_next;
      oldest    <= oldest_next;
      out_valid <= out_valid_next;
      if (head_we) begin
        head_vld[head_wa] <= 1'b1;
      end
    end
    head_rd_vld  <= head_vld[head_ra];
    key_q        <= key_q_next;
    cur          <= cur_next;
    prior        <= prior_next;
    slot         <= slot_next;
    steps        <= steps_next;
    ev_bkt       <= ev_bkt_next;
    dup          <= dup_next;
    evict        <= evict_next;
    duplicate    <= duplicate_next;
    entries_held <= entries_held_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= EMPTY)
    else $error("entry count above capacity");

  a_ends_agree: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> is_empty(newest) == is_empty(oldest))
    else $error("recency list ends disagree");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!out_valid || out_ready)) |=> out_valid)
    else $error("result not presented");

  a_empty_when_none: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && count == '0) |-> is_empty(newest))
    else $error("recency list holds entries with none stored");

endmodule
